// File: rtl/plq_pkg.sv
// Shared types, codes and defaults of the price-level order queue.
`default_nettype none
package plq_pkg;

    localparam int MAX_ORDERS_DEF = 64;

    // Request modes
    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_POP  = 3'd1;
    localparam logic [2:0] MODE_PEEK = 3'd2;
    localparam logic [2:0] MODE_CXL  = 3'd3;
    localparam logic [2:0] MODE_DEC  = 3'd4;
    localparam logic [2:0] MODE_LIST = 3'd5;

    // Result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_DUP      = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_OP,
        ST_LIST_RD,
        ST_LIST_PUT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        [2:0]  mode;
        logic        [31:0] order_id;
        logic signed [31:0] quantity;
    } req_t;

    typedef struct packed {
        logic        [2:0]  status;
        logic        [31:0] result_id;
        logic signed [31:0] result_quantity;
        logic               level_empty;
        logic               last;
    } rsp_t;

endpackage
`default_nettype wire

// File: rtl/price_level_order_queue_unit.sv
// Top level of the price-level order queue: slot memories, control sequencer.
//
// The block keeps the resting orders of one price level oldest first in a
// doubly linked list held in four slot memories (id, quantity, next, prev).
// Requests enter on req/req_valid/req_ready, results leave on
// rsp/rsp_valid/rsp_ready. One request is worked on at a time.
// Pop and peek go through read, operate and send states, and a request of any
// unused mode goes straight to send. Add, cancel and decrement search the id
// memory one slot per cycle, and that scan is the longest part of their work.
// List walks the level, each result taking a memory read, capture and send.
// Every result passes through an output register; while the receiver
// stalls, the sequencer holds in its send state and accepts no new request.
// Reset empties the level at once (slot-used bits, head, tail and count are
// flip-flops), so the block takes requests in the first cycle after reset.
`default_nettype none
module price_level_order_queue_unit #(
    parameter int MAX_ORDERS = plq_pkg::MAX_ORDERS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire plq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output plq_pkg::rsp_t      rsp
);
    import plq_pkg::*;

    localparam int AW = $clog2(MAX_ORDERS);
    localparam int CW = $clog2(MAX_ORDERS + 1);

    state_t              state_reg, state_next;
    logic [MAX_ORDERS-1:0] used_reg, used_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                out_reg, out_next;
    req_t                req_reg, req_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                mvld_reg, mvld_next;
    logic [AW-1:0]       midx_reg, midx_next;
    logic                fvld_reg, fvld_next;
    logic [AW-1:0]       fidx_reg, fidx_next;
    logic [AW-1:0]       tgt_reg, tgt_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       lcnt_reg, lcnt_next;
    rsp_t                pend_reg, pend_next;

    // Memory ports
    logic                id_we, qty_we, nxt_we, prv_we;
    logic [AW-1:0]       id_wa, qty_wa, nxt_wa, prv_wa;
    logic [31:0]         id_wd, qty_wd;
    logic [AW-1:0]       nxt_wd, prv_wd;
    logic                id_re, qty_re, nxt_re, prv_re;
    logic [AW-1:0]       id_ra, qty_ra, nxt_ra, prv_ra;
    logic [31:0]         id_rd, qty_rd;
    logic [AW-1:0]       nxt_rd, prv_rd;

    logic [AW-1:0]       chk_idx;
    logic [32:0]         diff;
    logic [31:0]         dec_q;

    plq_ram #(.W(32), .D(MAX_ORDERS)) u_id_ram (
        .clk(clk), .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd),
        .rd_en(id_re), .rd_addr(id_ra), .rd_data(id_rd)
    );
    plq_ram #(.W(32), .D(MAX_ORDERS)) u_qty_ram (
        .clk(clk), .wr_en(qty_we), .wr_addr(qty_wa), .wr_data(qty_wd),
        .rd_en(qty_re), .rd_addr(qty_ra), .rd_data(qty_rd)
    );
    plq_ram #(.W(AW), .D(MAX_ORDERS)) u_nxt_ram (
        .clk(clk), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
        .rd_en(nxt_re), .rd_addr(nxt_ra), .rd_data(nxt_rd)
    );
    plq_ram #(.W(AW), .D(MAX_ORDERS)) u_prv_ram (
        .clk(clk), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
        .rd_en(prv_re), .rd_addr(prv_ra), .rd_data(prv_rd)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = out_reg;

    // Slot whose id arrives from memory during the scan.
    assign chk_idx = AW'(scan_reg - CW'(1));

    // Saturating subtract for decrement.
    assign diff  = {qty_rd[31], qty_rd} - {req_reg.quantity[31], req_reg.quantity};
    assign dec_q = (diff[32] != diff[31]) ? (diff[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                          : diff[31:0];

    // Next state, memory controls and datapath.
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        out_next       = out_reg;
        req_next       = req_reg;
        scan_next      = scan_reg;
        mvld_next      = mvld_reg;
        midx_next      = midx_reg;
        fvld_next      = fvld_reg;
        fidx_next      = fidx_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        lcnt_next      = lcnt_reg;
        pend_next      = pend_reg;
        id_we  = 1'b0; id_wa  = '0; id_wd  = '0;
        qty_we = 1'b0; qty_wa = '0; qty_wd = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
        id_re  = 1'b0; id_ra  = '0;
        qty_re = 1'b0; qty_ra = '0;
        nxt_re = 1'b0; nxt_ra = '0;
        prv_re = 1'b0; prv_ra = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req;
                    pend_next = '{status: STAT_OK, result_id: '0, result_quantity: '0,
                                  level_empty: 1'b0, last: 1'b1};
                    case (req.mode) inside
                        MODE_ADD, MODE_CXL, MODE_DEC:
                        begin
                            scan_next  = '0;
                            mvld_next  = 1'b0;
                            fvld_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        MODE_POP, MODE_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = STAT_EMPTY;
                                state_next       = ST_EMIT;
                            end
                            else
                            begin
                                tgt_next   = head_reg;
                                state_next = ST_RD;
                            end
                        end
                        MODE_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = STAT_EMPTY;
                                state_next       = ST_EMIT;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                lcnt_next  = '0;
                                state_next = ST_LIST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue one id read per cycle, check the one read last cycle.
                if (scan_reg < CW'(MAX_ORDERS))
                begin
                    id_re = 1'b1;
                    id_ra = scan_reg[AW-1:0];
                end
                if (scan_reg != '0)
                begin
                    if (used_reg[chk_idx] && id_rd == req_reg.order_id && !mvld_reg)
                    begin
                        mvld_next = 1'b1;
                        midx_next = chk_idx;
                    end
                    if (!used_reg[chk_idx] && !fvld_reg)
                    begin
                        fvld_next = 1'b1;
                        fidx_next = chk_idx;
                    end
                end
                scan_next = scan_reg + CW'(1);
                if (scan_reg == CW'(MAX_ORDERS))
                begin
                    state_next = ST_EMIT;
                    if (req_reg.mode == MODE_ADD)
                    begin
                        if (mvld_next)
                        begin
                            pend_next.status = STAT_DUP;
                        end
                        else if (count_reg >= CW'(MAX_ORDERS) || !fvld_next)
                        begin
                            pend_next.status = STAT_FULL;
                        end
                        else
                        begin
                            // Link the new order behind the tail.
                            id_we  = 1'b1; id_wa  = fidx_next; id_wd  = req_reg.order_id;
                            qty_we = 1'b1; qty_wa = fidx_next; qty_wd = req_reg.quantity;
                            prv_we = 1'b1; prv_wa = fidx_next; prv_wd = tail_reg;
                            if (count_reg != '0)
                            begin
                                nxt_we = 1'b1; nxt_wa = tail_reg; nxt_wd = fidx_next;
                            end
                            else
                            begin
                                head_next = fidx_next;
                            end
                            tail_next                 = fidx_next;
                            used_next[fidx_next]      = 1'b1;
                            count_next                = count_reg + CW'(1);
                            pend_next.result_id       = req_reg.order_id;
                            pend_next.result_quantity = req_reg.quantity;
                        end
                    end
                    else if (!mvld_next)
                    begin
                        pend_next.status = STAT_NOTFOUND;
                    end
                    else
                    begin
                        tgt_next   = midx_next;
                        state_next = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                id_re  = 1'b1; id_ra  = tgt_reg;
                qty_re = 1'b1; qty_ra = tgt_reg;
                nxt_re = 1'b1; nxt_ra = tgt_reg;
                prv_re = 1'b1; prv_ra = tgt_reg;
                state_next = ST_OP;
            end

            ST_OP:
            begin
                state_next = ST_EMIT;
                if (req_reg.mode == MODE_DEC)
                begin
                    qty_we = 1'b1; qty_wa = tgt_reg; qty_wd = dec_q;
                    pend_next.result_id       = req_reg.order_id;
                    pend_next.result_quantity = dec_q;
                end
                else
                begin
                    pend_next.result_id       = id_rd;
                    pend_next.result_quantity = qty_rd;
                    if (req_reg.mode != MODE_PEEK)
                    begin
                        // Unlink the target slot.
                        if (count_reg <= CW'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (tgt_reg == head_reg)
                        begin
                            head_next = nxt_rd;
                        end
                        else if (tgt_reg == tail_reg)
                        begin
                            tail_next = prv_rd;
                        end
                        else
                        begin
                            nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = nxt_rd;
                            prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = prv_rd;
                        end
                        used_next[tgt_reg] = 1'b0;
                        count_next         = count_reg - CW'(1);
                    end
                end
            end

            ST_LIST_RD:
            begin
                id_re  = 1'b1; id_ra  = cur_reg;
                qty_re = 1'b1; qty_ra = cur_reg;
                nxt_re = 1'b1; nxt_ra = cur_reg;
                state_next = ST_LIST_PUT;
            end

            ST_LIST_PUT:
            begin
                pend_next.status          = STAT_OK;
                pend_next.result_id       = id_rd;
                pend_next.result_quantity = qty_rd;
                pend_next.last            = (CW'(lcnt_reg + CW'(1)) == count_reg);
                cur_next                  = nxt_rd;
                lcnt_next                 = lcnt_reg + CW'(1);
                state_next                = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    out_next             = pend_reg;
                    out_next.level_empty = (count_reg == '0);
                    rsp_valid_next       = 1'b1;
                    state_next           = pend_reg.last ? ST_IDLE : ST_LIST_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            scan_reg      <= '0;
            mvld_reg      <= 1'b0;
            fvld_reg      <= 1'b0;
            lcnt_reg      <= '0;
        end
        else
        begin
            used_reg      <= used_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            scan_reg      <= scan_next;
            mvld_reg      <= mvld_next;
            fvld_reg      <= fvld_next;
            lcnt_reg      <= lcnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        req_reg  <= req_next;
        midx_reg <= midx_next;
        fidx_reg <= fidx_next;
        tgt_reg  <= tgt_next;
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

    // The count never passes the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_ORDERS))
        else $error("order count exceeds slot count");

    // Used-slot map and order count agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == 32'(count_reg))
        else $error("slot map disagrees with order count");

    // An empty level has head and tail at slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == '0 && tail_reg == '0)
        else $error("empty level with stale head or tail");

endmodule
`default_nettype wire

// File: rtl/plq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plq_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [$clog2(D)-1:0] wr_addr,
    input  wire logic [W-1:0]         wr_data,
    input  wire logic                 rd_en,
    input  wire logic [$clog2(D)-1:0] rd_addr,
    output logic      [W-1:0]         rd_data
);
    logic [W-1:0] mem [D];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: sim/plq_checker.sv
// Checker for the price-level order queue: watches both channels, predicts results, compares.
`default_nettype none
module plq_checker
    import plq_pkg::*;
#(
    parameter int DEPTH = MAX_ORDERS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  wire req_t req,
    input  wire logic rsp_valid,
    input  wire logic rsp_ready,
    input  wire rsp_t rsp,
    output int        fail_count,
    output int        pending
);

    // Shadow copy of the level.
    logic [31:0]        lvl_id   [DEPTH];
    logic signed [31:0] lvl_qty  [DEPTH];
    int                 lvl_next [DEPTH];
    int                 lvl_prev [DEPTH];
    bit                 lvl_used [DEPTH];
    int                 lvl_head;
    int                 lvl_tail;
    int                 lvl_count;

    rsp_t expected_rsp_q[$];

    assign pending = expected_rsp_q.size();

    // Queue one expected response, emptiness taken after the state change.
    task automatic push_rsp(input logic [2:0] st, input logic [31:0] id,
                            input logic signed [31:0] q, input logic lst);
        rsp_t r;
        begin
            r.status = st;
            r.result_id = id;
            r.result_quantity = q;
            r.level_empty = (lvl_count == 0);
            r.last = lst;
            expected_rsp_q = {expected_rsp_q, r};
        end
    endtask

    function automatic int locate_id(input logic [31:0] id);
        int i;
        begin
            locate_id = -1;
            for (i = DEPTH - 1; i >= 0; i--)
                if (lvl_used[i] && lvl_id[i] == id)
                    locate_id = i;
        end
    endfunction

    task automatic unlink_order(input int s);
        begin
            if (lvl_count <= 1)
            begin
                lvl_head = 0;
                lvl_tail = 0;
            end
            else if (s == lvl_head)
            begin
                lvl_head = lvl_next[s];
            end
            else if (s == lvl_tail)
            begin
                lvl_tail = lvl_prev[s];
            end
            else
            begin
                lvl_next[lvl_prev[s]] = lvl_next[s];
                lvl_prev[lvl_next[s]] = lvl_prev[s];
            end
            lvl_used[s] = 0;
            if (lvl_count > 0)
                lvl_count--;
        end
    endtask

    // Apply one accepted request to the shadow level.
    task automatic apply_request(input req_t r);
        int s;
        int h;
        int i;
        logic [31:0] id;
        logic signed [31:0] q;
        longint d;
        begin
            case (r.mode) inside
                MODE_ADD:
                begin
                    s = 0;
                    while (s < DEPTH && lvl_used[s])
                        s++;
                    if (locate_id(r.order_id) >= 0)
                        push_rsp(STAT_DUP, 0, 0, 1);
                    else if (lvl_count >= DEPTH || s >= DEPTH)
                        push_rsp(STAT_FULL, 0, 0, 1);
                    else
                    begin
                        lvl_used[s] = 1;
                        lvl_id[s] = r.order_id;
                        lvl_qty[s] = r.quantity;
                        lvl_next[s] = 0;
                        lvl_prev[s] = 0;
                        if (lvl_count == 0)
                            lvl_head = s;
                        else
                        begin
                            lvl_next[lvl_tail] = s;
                            lvl_prev[s] = lvl_tail;
                        end
                        lvl_tail = s;
                        lvl_count++;
                        push_rsp(STAT_OK, r.order_id, r.quantity, 1);
                    end
                end
                MODE_POP, MODE_PEEK:
                begin
                    if (lvl_count == 0)
                        push_rsp(STAT_EMPTY, 0, 0, 1);
                    else
                    begin
                        h = lvl_head;
                        id = lvl_id[h];
                        q = lvl_qty[h];
                        if (r.mode == MODE_POP)
                            unlink_order(h);
                        push_rsp(STAT_OK, id, q, 1);
                    end
                end
                MODE_CXL:
                begin
                    s = locate_id(r.order_id);
                    if (s < 0)
                        push_rsp(STAT_NOTFOUND, 0, 0, 1);
                    else
                    begin
                        q = lvl_qty[s];
                        unlink_order(s);
                        push_rsp(STAT_OK, r.order_id, q, 1);
                    end
                end
                MODE_DEC:
                begin
                    s = locate_id(r.order_id);
                    if (s < 0)
                        push_rsp(STAT_NOTFOUND, 0, 0, 1);
                    else
                    begin
                        d = longint'(lvl_qty[s]) - longint'(r.quantity);
                        if (d < -64'sd2147483648)
                            d = -64'sd2147483648;
                        if (d > 64'sd2147483647)
                            d = 64'sd2147483647;
                        lvl_qty[s] = d[31:0];
                        push_rsp(STAT_OK, r.order_id, lvl_qty[s], 1);
                    end
                end
                MODE_LIST:
                begin
                    if (lvl_count == 0)
                        push_rsp(STAT_EMPTY, 0, 0, 1);
                    else
                    begin
                        h = lvl_head;
                        for (i = 0; i < lvl_count; i++)
                        begin
                            push_rsp(STAT_OK, lvl_id[h], lvl_qty[h], i + 1 == lvl_count);
                            h = lvl_next[h];
                        end
                    end
                end
                default: push_rsp(STAT_OK, 0, 0, 1);
            endcase
        end
    endtask

    // Compare each response against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_rsp_q.delete();
            lvl_head = 0;
            lvl_tail = 0;
            lvl_count = 0;
            for (int i = 0; i < DEPTH; i++)
                lvl_used[i] = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("checker: unexpected response %h", rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_rsp_q.pop_front();
                    if (rsp !== e)
                    begin
                        if (fail_count < 10)
                            $display({"checker: mismatch expected st=%0d id=%h q=%0d ",
                                      "e=%b l=%b, got st=%0d id=%h q=%0d e=%b l=%b"},
                                e.status, e.result_id, e.result_quantity, e.level_empty,
                                e.last, rsp.status, rsp.result_id, rsp.result_quantity,
                                rsp.level_empty, rsp.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                apply_request(req);
        end
    end

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Top of the price-level order queue testbench: clock, reset, stimulus and verdict.
`default_nettype none
module testbench;
    import plq_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 0;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    bit   stall_on = 0;

    logic [31:0] id_pool[$];

    price_level_order_queue_unit uut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    plq_checker chk (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    always #10 clk = ~clk;

    // Receiver stalls in runs, with calm stretches where it never stalls.
    always @(posedge clk)
    begin
        if (!stall_on)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_on <= ~stall_on;
    end

    // Present one request and hold it until accepted, then maybe idle.
    task automatic send_request(input logic [2:0] m, input logic [31:0] id,
                                input logic [31:0] q);
        req_t r;
        int gap;
        begin
            r.mode = m;
            r.order_id = id;
            r.quantity = q;
            req <= r;
            req_valid <= 1'b1;
            @(posedge clk);
            while (!req_ready)
                @(posedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                req_valid <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] pick_id();
        if (id_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        return $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 40);
    endfunction

    initial
    begin
        int i;
        logic [2:0] m;
        logic [31:0] id;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty level cases, extremes, duplicate, saturation.
        send_request(MODE_POP, 0, 0);
        send_request(MODE_PEEK, 0, 0);
        send_request(MODE_LIST, 0, 0);
        send_request(MODE_CXL, 5, 0);
        send_request(MODE_DEC, 5, 1);
        send_request(MODE_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(MODE_ADD, 32'h0, 32'h8000_0000);
        send_request(MODE_ADD, 32'hFFFF_FFFF, 7);
        send_request(MODE_ADD, 32'hA5A5_5A5A, 100);
        send_request(MODE_DEC, 32'h0, 1);
        send_request(MODE_DEC, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(MODE_DEC, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
        send_request(MODE_LIST, 0, 0);
        send_request(MODE_PEEK, 0, 0);
        send_request(MODE_CXL, 32'h0, 0);
        send_request(3'd6, 32'h1234, 9);
        send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_POP, 0, 0);
        send_request(MODE_POP, 0, 0);
        send_request(MODE_POP, 0, 0);
        // Fill to full, then one more and a list of 64.
        for (i = 0; i < 65; i++)
            send_request(MODE_ADD, 32'h100 + i, $urandom);
        send_request(MODE_ADD, 32'h100, 1);
        send_request(MODE_LIST, 0, 0);
        send_request(MODE_CXL, 32'h120, 0);
        send_request(MODE_CXL, 32'h13F, 0);
        send_request(MODE_ADD, 32'h7, 3);
        send_request(MODE_LIST, 0, 0);
        for (i = 0; i < 48; i++)
            send_request(MODE_POP, 0, 0);

        // Random part: mostly adds and id-based requests on a small id pool.
        for (i = 0; i < 32; i++)
        begin
            case ($urandom_range(0, 19)) inside
                [0:5]: m = MODE_ADD;
                [6:7]: m = MODE_POP;
                [8:9]: m = MODE_PEEK;
                [10:12]: m = MODE_CXL;
                [13:15]: m = MODE_DEC;
                [16:17]: m = MODE_LIST;
                default: m = $urandom_range(0, 7);
            endcase
            id = pick_id();
            if (m == MODE_ADD)
                id_pool = {id_pool, id};
            send_request(m, id, $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 500)
                - 100);
        end
        req_valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
